[hw/rtl/pfcs_pkg.sv]
// Shared types, register map and microcode program of the PLL frequency change sequencer.
package pfcs_pkg;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    localparam int DIV_BITS = 48;
    localparam logic [DIV_BITS-1:0] FILTER_NUM = 48'd226492416000000;
    localparam logic [5:0] NUM_TOP = 6'(DIV_BITS - 1);

    localparam logic [21:0] KHZ_MIN = 22'd100000;
    localparam logic [21:0] KHZ_MAX = 22'd2400000;
    localparam logic [21:0] KHZ_DIV2 = 22'd800000;
    localparam logic [21:0] KHZ_DIV4 = 22'd400000;
    localparam logic [21:0] KHZ_DIV8 = 22'd200000;

    localparam logic [10:0] REG_DIV = 11'h232;
    localparam logic [10:0] REG_LPF_EN = 11'h2A8;
    localparam logic [10:0] REG_LPF_CNT = 11'h2AE;
    localparam logic [10:0] REG_LPF_HI_L = 11'h2A4;
    localparam logic [10:0] REG_LPF_HI_H = 11'h2A6;
    localparam logic [10:0] REG_LPF_CTRL = 11'h2B0;
    localparam logic [10:0] REG_LPF_DIR = 11'h2B2;
    localparam logic [10:0] REG_LPF_LO_L = 11'h2A0;
    localparam logic [10:0] REG_LPF_LO_H = 11'h2A2;

    localparam logic [15:0] LPF_CNT_VAL = 16'h000F;
    localparam logic [15:0] LPF_DIR_VAL = 16'h1000;

    localparam logic [3:0] DIV_CODE_RESET = 4'd1;
    localparam logic [1:0] STEP_MAX = 2'd3;
    localparam logic [1:0] STEP_LAST = 2'd2;

    typedef enum logic [1:0] {
        WM_PLAIN  = 2'd0,
        WM_OR     = 2'd1,
        WM_NIBBLE = 2'd2
    } wmode_t;

    typedef enum logic [2:0] {
        DS_CONST,
        DS_LPF_LO,
        DS_LPF_HI,
        DS_PEND_LO,
        DS_PEND_HI,
        DS_DIV_UP,
        DS_DIV_DOWN
    } dsel_t;

    typedef enum logic [1:0] {
        LS_NO,
        LS_YES,
        LS_NO_HALVE,
        LS_DOWN_END
    } lsel_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_SETUP,
        ACT_DIV_STEP,
        ACT_DOUBLE,
        ACT_HALVE,
        ACT_COMMIT_UP,
        ACT_ARM,
        ACT_DOWN_INIT,
        ACT_COMMIT_DOWN
    } act_t;

    typedef enum logic [2:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_DIV_BUSY,
        JC_UP_DONE,
        JC_DOWN_DONE,
        JC_NOT_GO,
        JC_END
    } jc_t;

    typedef logic [4:0] pc_t;

    localparam pc_t PC_REQ = 5'd0;
    localparam pc_t PC_STAT = 5'd11;

    typedef struct packed {
        logic        emit;
        logic [10:0] idx;
        dsel_t       dsel;
        logic [15:0] cdata;
        wmode_t      mode;
        lsel_t       lsel;
        act_t        act;
        jc_t         jc;
        pc_t         target;
    } ctrl_word_t;

    // Microcode: a request runs from PC_REQ, a status item from PC_STAT.
    function automatic ctrl_word_t rom_word(input pc_t pc);
        ctrl_word_t w;
        w = '{1'b0, 11'd0, DS_CONST, 16'd0, WM_PLAIN, LS_NO, ACT_NONE, JC_END, PC_REQ};
        unique case (pc)
            5'd0:  w = '{1'b0, 11'd0, DS_CONST, 16'd0, WM_PLAIN, LS_NO,
                         ACT_SETUP, JC_NEXT, PC_REQ};
            5'd1:  w = '{1'b0, 11'd0, DS_CONST, 16'd0, WM_PLAIN, LS_NO,
                         ACT_DIV_STEP, JC_DIV_BUSY, 5'd1};
            5'd2:  w = '{1'b0, 11'd0, DS_CONST, 16'd0, WM_PLAIN, LS_NO,
                         ACT_NONE, JC_UP_DONE, 5'd4};
            5'd3:  w = '{1'b1, REG_DIV, DS_DIV_UP, 16'd0, WM_NIBBLE, LS_NO,
                         ACT_DOUBLE, JC_ALWAYS, 5'd2};
            5'd4:  w = '{1'b1, REG_LPF_EN, DS_CONST, 16'h0000, WM_PLAIN, LS_NO,
                         ACT_COMMIT_UP, JC_NEXT, PC_REQ};
            5'd5:  w = '{1'b1, REG_LPF_CNT, DS_CONST, LPF_CNT_VAL, WM_PLAIN, LS_NO,
                         ACT_NONE, JC_NEXT, PC_REQ};
            5'd6:  w = '{1'b1, REG_LPF_HI_L, DS_LPF_LO, 16'd0, WM_PLAIN, LS_NO,
                         ACT_NONE, JC_NEXT, PC_REQ};
            5'd7:  w = '{1'b1, REG_LPF_HI_H, DS_LPF_HI, 16'd0, WM_PLAIN, LS_NO,
                         ACT_NONE, JC_NEXT, PC_REQ};
            5'd8:  w = '{1'b1, REG_LPF_CTRL, DS_CONST, 16'h0001, WM_PLAIN, LS_NO,
                         ACT_NONE, JC_NEXT, PC_REQ};
            5'd9:  w = '{1'b1, REG_LPF_DIR, DS_CONST, LPF_DIR_VAL, WM_OR, LS_NO,
                         ACT_NONE, JC_NEXT, PC_REQ};
            5'd10: w = '{1'b1, REG_LPF_EN, DS_CONST, 16'h0001, WM_PLAIN, LS_YES,
                         ACT_ARM, JC_END, PC_REQ};
            5'd11: w = '{1'b0, 11'd0, DS_CONST, 16'd0, WM_PLAIN, LS_NO,
                         ACT_DOWN_INIT, JC_NOT_GO, PC_REQ};
            5'd12: w = '{1'b1, REG_LPF_LO_L, DS_PEND_LO, 16'd0, WM_PLAIN, LS_NO,
                         ACT_NONE, JC_NEXT, PC_REQ};
            5'd13: w = '{1'b1, REG_LPF_LO_H, DS_PEND_HI, 16'd0, WM_PLAIN, LS_NO_HALVE,
                         ACT_NONE, JC_NEXT, PC_REQ};
            5'd14: w = '{1'b0, 11'd0, DS_CONST, 16'd0, WM_PLAIN, LS_NO,
                         ACT_NONE, JC_DOWN_DONE, 5'd16};
            5'd15: w = '{1'b1, REG_DIV, DS_DIV_DOWN, 16'd0, WM_NIBBLE, LS_DOWN_END,
                         ACT_HALVE, JC_ALWAYS, 5'd14};
            5'd16: w = '{1'b0, 11'd0, DS_CONST, 16'd0, WM_PLAIN, LS_NO,
                         ACT_COMMIT_DOWN, JC_END, PC_REQ};
            default: w = '{1'b0, 11'd0, DS_CONST, 16'd0, WM_PLAIN, LS_NO,
                           ACT_NONE, JC_END, PC_REQ};
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/pll_frequency_change_sequencer_core.sv]
// PLL frequency change sequencer: microcoded control over a small datapath and serial divider.
//
// Input channel (s_*): one transfer per item. s_tuser is the item kind: 0 carries a
// target CPU clock in kHz (s_tdata[21:0]), 1 carries a loop filter status read whose
// done flag is s_tdata[22]. The block works on one item at a time; s_tready is high
// whenever no item is in progress.
// Result channel (m_*): one transfer per PLL register write, m_tlast marks the final
// write caused by an item. A status item that finds no armed filter, or done low,
// causes no transfer.
// Steps: a request runs a setup step, a restoring division over the 48 numerator bits
// (one quotient bit a cycle, 432e6 * 2^19 over the scaled rate), a test and a write per
// doubling step (up to three) with a final test, then seven filter writes. A status item
// runs a test step that ends it when it writes nothing, else two filter writes, a test and
// a write per halving step (up to three) with a final test, and a commit step.
// The divider loop sets the request rate; the write steps set the status rate.
// Stalls: each write sits in the output register until taken; the program step that
// emits holds until the register is free, and a finished result never blocks the
// next input transfer.
// Reset: the divider shadow returns to code 1 (divide by two), no filter is armed,
// the output register empties and the program counter idles.
module pll_frequency_change_sequencer_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pfcs_pkg::S_TDATA_W-1:0]  s_tdata,   // [21:0] target_khz, [22] done_bit
    input  logic                            s_tuser,   // [0] kind
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pfcs_pkg::M_TDATA_W-1:0]  m_tdata,   // [10:0] reg_index, [26:11] reg_data,
                                                       // [28:27] write_mode
    output logic                            m_tlast
);
    import pfcs_pkg::*;

    // Control state
    logic       busy_reg, busy_next;
    pc_t        pc_reg, pc_next;
    logic       m_valid_reg, m_valid_next;
    logic [3:0] cur_div_reg, cur_div_next;
    logic       waiting_reg, waiting_next;
    logic [3:0] pend_div_reg, pend_div_next;
    logic [22:0] pend_lpf_reg, pend_lpf_next;

    // Datapath
    logic [21:0] target_reg, target_next;
    logic        done_reg, done_next;
    logic [27:0] rate_reg, rate_next;
    logic [4:0]  div_reg, div_next;
    logic [4:0]  tmp_reg, tmp_next;
    logic [1:0]  steps_reg, steps_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [27:0] rem_reg, rem_next;
    logic [22:0] quot_reg, quot_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic        m_last_reg, m_last_next;

    // Step decode and helpers
    ctrl_word_t  word;
    logic        s_accept;
    logic        out_free;
    logic        retire;
    logic        out_load;
    logic        jump;
    logic [4:0]  cur_div;
    logic [4:0]  pend_div;
    logic [4:0]  tmp_up;
    logic [4:0]  tmp_dn;
    logic [21:0] t_in;
    logic [21:0] t_clamped;
    logic [31:0] t_ext;
    logic [31:0] t_x1000;
    logic [27:0] rate_base;
    logic [1:0]  rate_sh;
    logic [4:0]  div_sel;
    logic [28:0] rem_sh;
    logic [28:0] rem_diff;
    logic        q_bit;
    logic [15:0] w_data;
    logic        w_last;

    assign word      = rom_word(pc_reg);
    assign s_tready  = !busy_reg;
    assign s_accept  = s_tvalid && !busy_reg;
    assign out_free  = !m_valid_reg || m_tready;
    assign retire    = busy_reg && (!word.emit || out_free);
    assign out_load  = retire && word.emit;
    assign cur_div   = {1'b0, cur_div_reg} + 5'd1;
    assign pend_div  = {1'b0, pend_div_reg} + 5'd1;
    assign tmp_up    = {tmp_reg[3:0], 1'b0};
    assign tmp_dn    = {1'b0, tmp_reg[4:1]};

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // Clamp the request at the input
    always_comb begin
        t_in = s_tdata[21:0];
        if (t_in < KHZ_MIN) begin
            t_clamped = KHZ_MIN;
        end else if (t_in > KHZ_MAX) begin
            t_clamped = KHZ_MAX;
        end else begin
            t_clamped = t_in;
        end
    end

    // Post-divider and scaled rate: ((t * 1000) / 16) * div / 2
    always_comb begin
        t_ext   = {10'd0, target_reg};
        t_x1000 = (t_ext << 10) - (t_ext << 4) - (t_ext << 3);
        rate_base = t_x1000[31:4];
        if (target_reg >= KHZ_DIV2) begin
            div_sel = 5'd2;
            rate_sh = 2'd0;
        end else if (target_reg >= KHZ_DIV4) begin
            div_sel = 5'd4;
            rate_sh = 2'd1;
        end else if (target_reg >= KHZ_DIV8) begin
            div_sel = 5'd8;
            rate_sh = 2'd2;
        end else begin
            div_sel = 5'd16;
            rate_sh = 2'd3;
        end
    end

    // One restoring division step
    always_comb begin
        rem_sh   = {rem_reg, FILTER_NUM[NUM_TOP - cnt_reg]};
        rem_diff = rem_sh - {1'b0, rate_reg};
        q_bit    = (rem_sh >= {1'b0, rate_reg});
    end

    // Write data and last flag for the current step
    always_comb begin
        case (word.dsel)
            DS_CONST:    w_data = word.cdata;
            DS_LPF_LO:   w_data = quot_reg[15:0];
            DS_LPF_HI:   w_data = {9'd0, quot_reg[22:16]};
            DS_PEND_LO:  w_data = pend_lpf_reg[15:0];
            DS_PEND_HI:  w_data = {9'd0, pend_lpf_reg[22:16]};
            DS_DIV_UP:   w_data = {12'd0, 4'(tmp_up - 5'd1)};
            DS_DIV_DOWN: w_data = {12'd0, 4'(tmp_dn - 5'd1)};
            default:     w_data = word.cdata;
        endcase
        case (word.lsel)
            LS_NO:       w_last = 1'b0;
            LS_YES:      w_last = 1'b1;
            LS_NO_HALVE: w_last = (pend_div >= cur_div);
            LS_DOWN_END: w_last = (tmp_dn == pend_div) || (steps_reg == STEP_LAST);
            default:     w_last = 1'b0;
        endcase
    end

    // Jump condition
    always_comb begin
        unique case (word.jc)
            JC_NEXT:      jump = 1'b0;
            JC_ALWAYS:    jump = 1'b1;
            JC_DIV_BUSY:  jump = (cnt_reg != NUM_TOP);
            JC_UP_DONE:   jump = (div_reg <= cur_div) || (tmp_reg == div_reg)
                                 || (steps_reg == STEP_MAX);
            JC_DOWN_DONE: jump = (pend_div >= cur_div) || (tmp_reg == pend_div)
                                 || (steps_reg == STEP_MAX);
            JC_NOT_GO:    jump = !(waiting_reg && done_reg);
            JC_END:       jump = 1'b1;
            default:      jump = 1'b1;
        endcase
    end

    // Sequencer: next state of every register
    always_comb begin
        busy_next     = busy_reg;
        pc_next       = pc_reg;
        m_valid_next  = m_valid_reg;
        cur_div_next  = cur_div_reg;
        waiting_next  = waiting_reg;
        pend_div_next = pend_div_reg;
        pend_lpf_next = pend_lpf_reg;
        target_next   = target_reg;
        done_next     = done_reg;
        rate_next     = rate_reg;
        div_next      = div_reg;
        tmp_next      = tmp_reg;
        steps_next    = steps_reg;
        cnt_next      = cnt_reg;
        rem_next      = rem_reg;
        quot_next     = quot_reg;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (s_accept) begin
            busy_next   = 1'b1;
            pc_next     = s_tuser ? PC_STAT : PC_REQ;
            target_next = t_clamped;
            done_next   = s_tdata[22];
        end

        if (out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = {3'd0, word.mode, w_data, word.idx};
            m_last_next  = w_last;
        end

        if (retire) begin
            case (word.act)
                ACT_SETUP: begin
                    rate_next  = rate_base << rate_sh;
                    div_next   = div_sel;
                    tmp_next   = cur_div;
                    steps_next = 2'd0;
                    cnt_next   = 6'd0;
                    rem_next   = 28'd0;
                    quot_next  = 23'd0;
                end
                ACT_DIV_STEP: begin
                    rem_next  = q_bit ? rem_diff[27:0] : rem_sh[27:0];
                    quot_next = {quot_reg[21:0], q_bit};
                    cnt_next  = cnt_reg + 6'd1;
                end
                ACT_DOUBLE: begin
                    tmp_next   = tmp_up;
                    steps_next = steps_reg + 2'd1;
                end
                ACT_HALVE: begin
                    tmp_next   = tmp_dn;
                    steps_next = steps_reg + 2'd1;
                end
                ACT_COMMIT_UP: begin
                    if (div_reg > cur_div) begin
                        cur_div_next = 4'(div_reg - 5'd1);
                    end
                end
                ACT_ARM: begin
                    pend_div_next = 4'(div_reg - 5'd1);
                    pend_lpf_next = quot_reg;
                    waiting_next  = 1'b1;
                end
                ACT_DOWN_INIT: begin
                    tmp_next   = cur_div;
                    steps_next = 2'd0;
                end
                ACT_COMMIT_DOWN: begin
                    if (pend_div < cur_div) begin
                        cur_div_next = pend_div_reg;
                    end
                    waiting_next = 1'b0;
                end
                default: ;
            endcase

            if (word.jc == JC_END || word.jc == JC_NOT_GO) begin
                if (jump) begin
                    busy_next = 1'b0;
                end else begin
                    pc_next = pc_reg + 5'd1;
                end
            end else if (jump) begin
                pc_next = word.target;
            end else begin
                pc_next = pc_reg + 5'd1;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            pc_reg       <= PC_REQ;
            m_valid_reg  <= 1'b0;
            cur_div_reg  <= DIV_CODE_RESET;
            waiting_reg  <= 1'b0;
            pend_div_reg <= 4'd0;
            pend_lpf_reg <= 23'd0;
        end else begin
            busy_reg     <= busy_next;
            pc_reg       <= pc_next;
            m_valid_reg  <= m_valid_next;
            cur_div_reg  <= cur_div_next;
            waiting_reg  <= waiting_next;
            pend_div_reg <= pend_div_next;
            pend_lpf_reg <= pend_lpf_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        target_reg <= target_next;
        done_reg   <= done_next;
        rate_reg   <= rate_next;
        div_reg    <= div_next;
        tmp_reg    <= tmp_next;
        steps_reg  <= steps_next;
        cnt_reg    <= cnt_next;
        rem_reg    <= rem_next;
        quot_reg   <= quot_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

`ifndef ASSERT_OFF
    a_shadow_code: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_div_reg == 4'd1 || cur_div_reg == 4'd3 || cur_div_reg == 4'd7
        || cur_div_reg == 4'd15)
        else $error("divider shadow left the power-of-two codes");

    a_pending_code: assert property (@(posedge aclk) disable iff (!aresetn)
        waiting_reg |-> (pend_div_reg == 4'd1 || pend_div_reg == 4'd3
        || pend_div_reg == 4'd7 || pend_div_reg == 4'd15))
        else $error("armed filter holds a bad divider code");

    a_no_emit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> !out_load)
        else $error("write emitted while sequencer idle");

    a_arm_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (retire && word.act == ACT_ARM) |-> cnt_reg == 6'(DIV_BITS))
        else $error("filter armed before division finished");
`endif

endmodule

[bench/pll_frequency_change_sequencer_core_tb.sv]
// Self-checking testbench for the PLL frequency change sequencer core.
`timescale 1ns / 100ps

module pll_frequency_change_sequencer_core_tb;

    // Item kind carried on s_tuser.
    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // PLL register word indexes.
    localparam logic [10:0] ADDR_DIV      = 11'h232;
    localparam logic [10:0] ADDR_LPF_EN   = 11'h2A8;
    localparam logic [10:0] ADDR_LPF_CNT  = 11'h2AE;
    localparam logic [10:0] ADDR_LPF_HI_L = 11'h2A4;
    localparam logic [10:0] ADDR_LPF_HI_H = 11'h2A6;
    localparam logic [10:0] ADDR_LPF_CTRL = 11'h2B0;
    localparam logic [10:0] ADDR_LPF_DIR  = 11'h2B2;
    localparam logic [10:0] ADDR_LPF_LO_L = 11'h2A0;
    localparam logic [10:0] ADDR_LPF_LO_H = 11'h2A2;

    // Target clock limits and post-divider thresholds, in kHz.
    localparam logic [63:0] TARGET_MIN   = 64'd100000;
    localparam logic [63:0] TARGET_MAX   = 64'd2400000;
    localparam logic [63:0] THRESH_DIV2  = 64'd800000;
    localparam logic [63:0] THRESH_DIV4  = 64'd400000;
    localparam logic [63:0] THRESH_DIV8  = 64'd200000;
    localparam logic [63:0] FILTER_NUMERATOR = 64'd432000000 * 64'd524288;

    localparam int MAX_WRITES    = 10;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int DRAIN_CYCLES  = 80;
    localparam int LONG_HOLD     = 300;

    typedef struct packed {
        logic [10:0] idx;
        logic [15:0] data;
        logic [1:0]  mode;
        logic        last;
    } reg_write_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [pfcs_pkg::S_TDATA_W-1:0]  s_tdata;
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [pfcs_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            m_tlast;

    // Predictor state: divider shadow and the armed filter sequence.
    logic [3:0]  shadow_div_code;
    logic        filter_armed;
    logic [3:0]  armed_div_code;
    logic [22:0] armed_filter_value;

    reg_write_t  expected_writes[$];
    reg_write_t  write_batch[0:MAX_WRITES-1];
    int          batch_len;

    int          mismatch_count;
    int          cycle_count;
    int          tx_gap_max;
    int          rx_stall_max;
    int          rx_hold_cycles;

    pll_frequency_change_sequencer_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Append one register write to the batch caused by the current item.
    task automatic emit_write(input logic [10:0] idx, input logic [15:0] data,
                              input logic [1:0] mode);
        write_batch[batch_len] = '{idx, data, mode, 1'b0};
        batch_len++;
    endtask

    // Work out the register writes that one accepted item causes and queue them.
    task automatic predict_writes(input logic kind, input logic [pfcs_pkg::S_TDATA_W-1:0] data);
        logic [63:0] khz;
        logic [63:0] rate;
        logic [63:0] quot;
        logic [22:0] lpf;
        logic [4:0]  div_n;
        logic [4:0]  cur_n;
        logic [4:0]  step_n;
        reg_write_t  w;
        int          k;
        batch_len = 0;
        if (kind == KIND_REQUEST) begin
            // Clamp the target, then pick the post-divider from the thresholds.
            khz = 64'(data[21:0]);
            if (khz < TARGET_MIN) khz = TARGET_MIN;
            if (khz > TARGET_MAX) khz = TARGET_MAX;
            if (khz >= THRESH_DIV2)      div_n = 5'd2;
            else if (khz >= THRESH_DIV4) div_n = 5'd4;
            else if (khz >= THRESH_DIV8) div_n = 5'd8;
            else                         div_n = 5'd16;
            rate = (khz * 64'd1000) / 64'd16 * 64'(div_n) / 64'd2;
            quot = FILTER_NUMERATOR / rate;
            lpf  = quot[22:0];

            // Double the divider first when it has to rise.
            cur_n = {1'b0, shadow_div_code} + 5'd1;
            if (div_n > cur_n) begin
                step_n = cur_n;
                for (k = 0; k < 3 && step_n != div_n; k++) begin
                    step_n = step_n << 1;
                    emit_write(ADDR_DIV, {12'd0, 4'(step_n - 5'd1)}, pfcs_pkg::WM_NIBBLE);
                end
                shadow_div_code = 4'(div_n - 5'd1);
            end

            emit_write(ADDR_LPF_EN,   16'h0000, pfcs_pkg::WM_PLAIN);
            emit_write(ADDR_LPF_CNT,  16'h000F, pfcs_pkg::WM_PLAIN);
            emit_write(ADDR_LPF_HI_L, lpf[15:0], pfcs_pkg::WM_PLAIN);
            emit_write(ADDR_LPF_HI_H, {9'd0, lpf[22:16]}, pfcs_pkg::WM_PLAIN);
            emit_write(ADDR_LPF_CTRL, 16'h0001, pfcs_pkg::WM_PLAIN);
            emit_write(ADDR_LPF_DIR,  16'h1000, pfcs_pkg::WM_OR);
            emit_write(ADDR_LPF_EN,   16'h0001, pfcs_pkg::WM_PLAIN);

            armed_div_code     = 4'(div_n - 5'd1);
            armed_filter_value = lpf;
            filter_armed       = 1'b1;
        end else if (filter_armed && data[22]) begin
            // Done: store the filter value low, then halve down if needed.
            emit_write(ADDR_LPF_LO_L, armed_filter_value[15:0], pfcs_pkg::WM_PLAIN);
            emit_write(ADDR_LPF_LO_H, {9'd0, armed_filter_value[22:16]}, pfcs_pkg::WM_PLAIN);
            cur_n = {1'b0, shadow_div_code} + 5'd1;
            div_n = {1'b0, armed_div_code} + 5'd1;
            if (div_n < cur_n) begin
                step_n = cur_n;
                for (k = 0; k < 3 && step_n != div_n; k++) begin
                    step_n = step_n >> 1;
                    emit_write(ADDR_DIV, {12'd0, 4'(step_n - 5'd1)}, pfcs_pkg::WM_NIBBLE);
                end
                shadow_div_code = armed_div_code;
            end
            filter_armed = 1'b0;
        end
        for (k = 0; k < batch_len; k++) begin
            w = write_batch[k];
            w.last = (k == batch_len - 1);
            expected_writes.push_back(w);
        end
    endtask

    // Predict on every input transfer; values are sampled before the edge updates them.
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && s_tvalid === 1'b1 && s_tready === 1'b1) begin
            predict_writes(s_tuser, s_tdata);
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
        end
    endtask

    // Compare each result transfer, field by field, with the oldest expected write.
    always @(posedge aclk) begin : result_check
        reg_write_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (expected_writes.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected write, expected none, actual tdata 0x%0h last %0b",
                         $time, m_tdata, m_tlast);
            end else begin
                want = expected_writes.pop_front();
                check_field("reg_index",  32'(want.idx),  32'(m_tdata[10:0]));
                check_field("reg_data",   32'(want.data), 32'(m_tdata[26:11]));
                check_field("write_mode", 32'(want.mode), 32'(m_tdata[28:27]));
                check_field("last",       32'(want.last), 32'(m_tlast));
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls per transfer, plus an optional long hold
    // ------------------------------------------------------------------

    initial begin : result_receiver
        int stall;
        int hold;
        m_tready = 1'b0;
        forever begin
            // Hold off for a long stretch when a test asks for it.
            if (rx_hold_cycles > 0) begin
                hold = rx_hold_cycles;
                rx_hold_cycles = 0;
                m_tready = 1'b0;
                repeat (hold) @(negedge aclk);
            end
            stall = (rx_stall_max == 0) ? 0 : $urandom_range(0, rx_stall_max);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            // Offer ready until one transfer completes, then draw a new stall.
            m_tready = 1'b1;
            @(posedge aclk);
            while (m_tvalid !== 1'b1) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Send one item: idle for a random gap, then hold valid until the transfer.
    // Enter and leave at a falling edge.
    task automatic send_item(input logic kind, input logic [21:0] target,
                             input logic done_bit);
        int gap;
        gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {1'b0, done_bit, target};
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        @(negedge aclk);
    endtask

    // The unused field of each kind carries random bits.
    task automatic send_request(input logic [21:0] target);
        send_item(KIND_REQUEST, target, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_status(input logic done_bit);
        send_item(KIND_STATUS, 22'($urandom), done_bit);
    endtask

    // Draw a target: mostly in range, some around the thresholds, some out of range.
    function automatic logic [21:0] random_target();
        int base;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: base = 100000;
                    1: base = 200000;
                    2: base = 400000;
                    3: base = 800000;
                    default: base = 2400000;
                endcase
                return 22'(base - 1 + $urandom_range(0, 2));
            end
            1: return 22'($urandom_range(0, 99999));
            2: return 22'($urandom_range(2400001, 22'h3FFFFF));
            default: return 22'($urandom_range(100000, 2400000));
        endcase
    endfunction

    // Clamping at both ends, the full three-step doubling and halving, and
    // status items that find done low or nothing armed.
    task automatic test_clamp_and_full_swing();
        send_request(22'd0);
        send_status(1'b1);
        send_request(22'h3FFFFF);
        send_status(1'b0);
        send_status(1'b1);
        send_status(1'b1);
    endtask

    // Each divider threshold from both sides, single doubling steps.
    task automatic test_divider_thresholds();
        send_request(22'd800000);
        send_status(1'b1);
        send_request(22'd799999);
        send_status(1'b1);
        send_request(22'd400000);
        send_request(22'd399999);
        send_status(1'b1);
        send_request(22'd200000);
        send_status(1'b1);
        send_request(22'd199999);
        send_status(1'b1);
    endtask

    // A request while the filter is armed drops the earlier store and halving.
    task automatic test_abandoned_sequences();
        send_request(22'd100000);
        send_request(22'd2400000);
        send_status(1'b1);
        send_request(22'd99999);
        send_request(22'd2400001);
        send_status(1'b1);
        send_status(1'b1);
    endtask

    // Mostly complete change sequences with random targets, mixed with noise:
    // early done-low status, abandoned requests, missing and stray status items.
    task automatic test_random_changes(input int tx_max, input int rx_max,
                                       input int item_quota);
        int sent;
        int pick;
        tx_gap_max   = tx_max;
        rx_stall_max = rx_max;
        sent = 0;
        while (sent < item_quota) begin
            pick = $urandom_range(0, 9);
            send_request(random_target());
            sent++;
            if (pick == 0) begin
                send_status(1'b0);
                sent++;
            end
            if (pick == 1) begin
                send_request(random_target());
                sent++;
            end
            if (pick != 2) begin
                send_status(1'b1);
                sent++;
            end
            if (pick == 3) begin
                send_status(1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    // Hold the receiver off while the sender keeps offering back to back,
    // so the output register fills and the input stalls.
    task automatic test_output_backpressure();
        int k;
        tx_gap_max     = 0;
        rx_stall_max   = 4;
        rx_hold_cycles = LONG_HOLD;
        for (k = 0; k < 6; k++) begin
            send_request(random_target());
            send_status(1'b1);
        end
    endtask

    // Run watchdog.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL pll_frequency_change_sequencer_core");
        $finish;
    end

    initial begin
        // Drive every input to a known value before reset releases.
        aresetn            = 1'b0;
        s_tvalid           = 1'b0;
        s_tuser            = KIND_REQUEST;
        s_tdata            = '0;
        tx_gap_max         = 16;
        rx_stall_max       = 16;
        rx_hold_cycles     = 0;
        mismatch_count     = 0;
        shadow_div_code    = 4'd1;
        filter_armed       = 1'b0;
        armed_div_code     = 4'd0;
        armed_filter_value = 23'd0;
        batch_len          = 0;

        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        test_clamp_and_full_swing();
        test_divider_thresholds();
        test_abandoned_sequences();
        test_random_changes(16, 16, 18);
        test_random_changes(0, 0, 16);
        test_random_changes(0, 16, 16);
        test_random_changes(16, 0, 18);
        test_output_backpressure();
        s_tvalid = 1'b0;

        // Drain outstanding writes, then let any silent status item finish.
        while (expected_writes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (expected_writes.size() != 0) begin
            mismatch_count += expected_writes.size();
            $display("%0t: %0d expected writes never arrived", $time, expected_writes.size());
        end

        if (mismatch_count == 0) begin
            $display("PASS pll_frequency_change_sequencer_core");
        end else begin
            $display("FAIL pll_frequency_change_sequencer_core");
        end
        $finish;
    end

endmodule

[pll_frequency_change_sequencer_core.f]
hw/rtl/pfcs_pkg.sv
hw/rtl/pll_frequency_change_sequencer_core.sv
bench/pll_frequency_change_sequencer_core_tb.sv
